// ===== src/cv3_pkg.sv =====
// Shared types and constants of the 3x3 image filter unit.
// No dependencies; imported by every other file of the unit.
package cv3_pkg;

   localparam int PIX_W      = 8;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 12;
   localparam int WIN_N      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int MAX_LINE_DEFAULT = 1024;
   localparam int LINE_CAP         = 1024;
   localparam int WIDTH_CAP        = 1022;
   localparam int HEIGHT_CAP       = 4094;
   localparam int WIDTH_RESET      = 640;
   localparam int HEIGHT_RESET     = 480;
   localparam int FIRST_OUT        = 2;

   // Reciprocals scaled by 2^16, rounded up; exact for the sum ranges involved.
   localparam int RECIP_SHIFT  = 16;
   localparam int SMOOTH_RECIP = 7282;
   localparam int SHARP_RECIP  = 21846;
   localparam int SAT_MAX      = 255;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [WIN_N-1:0] window_type;

   typedef enum logic [1:0] {
      MODE_SMOOTH,
      MODE_BLUR,
      MODE_SHARPEN,
      MODE_MEAN_REMOVAL
   } filter_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_MODE,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic      en;
      pixel_type above_data;
      pixel_type two_above_data;
   } lb_write_type;

endpackage

// ===== src/cv3_line_buffer.sv =====
// Two line memories holding the previous two rows, with registered read data.
// Clears both memories after reset, one entry per cycle. Uses cv3_pkg.
module cv3_line_buffer #(
   parameter int DEPTH  = cv3_pkg::LINE_CAP,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cv3_pkg::lb_write_type wr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [ADDR_W-1:0]     rd_addr,
   output cv3_pkg::pixel_type    rd_above,
   output cv3_pkg::pixel_type    rd_two_above,
   output logic                  busy
);
   import cv3_pkg::*;

   pixel_type mem_above [DEPTH];
   pixel_type mem_two_above [DEPTH];

   logic              clr_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   pixel_type         rd_above_ff;
   pixel_type         rd_two_above_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem_above[clr_addr_ff]     <= '0;
         mem_two_above[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem_above[wr_addr]     <= wr.above_data;
         mem_two_above[wr_addr] <= wr.two_above_data;
      end
      rd_above_ff     <= mem_above[rd_addr];
      rd_two_above_ff <= mem_two_above[rd_addr];
   end

   assign rd_above     = rd_above_ff;
   assign rd_two_above = rd_two_above_ff;
   assign busy         = clr_ff;

endmodule

// ===== src/cv3_kernel.sv =====
// Weighted 3x3 sum, constant division and clamp for the four kernels.
// Purely combinational; uses cv3_pkg.
module cv3_kernel (
   input  cv3_pkg::window_type      win,
   input  cv3_pkg::filter_mode_type mode,
   output cv3_pkg::pixel_type       result
);
   import cv3_pkg::*;

   logic [9:0]         corners;
   logic [9:0]         cross_sum;
   logic [11:0]        sum_all;
   logic [11:0]        ring;
   logic [11:0]        blur_sum;
   logic [24:0]        smooth_prod;
   logic signed [12:0] sharp_v;
   logic [26:0]        sharp_prod;
   logic [9:0]         sharp_q;
   logic signed [12:0] mean_v;

   always_comb begin
      corners     = 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
      cross_sum   = 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
      sum_all     = 12'(corners) + 12'(cross_sum) + 12'(win[4]);
      ring        = sum_all - 12'(win[4]);
      blur_sum    = 12'(corners) + {1'b0, cross_sum, 1'b0} + {2'b0, win[4], 2'b0};
      smooth_prod = 25'(sum_all) * 25'(SMOOTH_RECIP);
      sharp_v     = $signed(13'(win[4])) * 13'sd11 - $signed({2'b0, cross_sum, 1'b0});
      sharp_prod  = 27'(sharp_v[11:0]) * 27'(SHARP_RECIP);
      sharp_q     = sharp_prod[RECIP_SHIFT +: 10];
      mean_v      = $signed(13'(win[4])) * 13'sd9 - $signed({1'b0, ring});
   end

   always_comb begin
      case (mode)
         MODE_SMOOTH: begin
            result = smooth_prod[RECIP_SHIFT +: PIX_W];
         end
         MODE_BLUR: begin
            result = blur_sum[11:4];
         end
         MODE_SHARPEN: begin
            if (sharp_v < 13'sd0) begin
               result = '0;
            end else if (sharp_q > 10'(SAT_MAX)) begin
               result = PIX_W'(SAT_MAX);
            end else begin
               result = sharp_q[PIX_W-1:0];
            end
         end
         MODE_MEAN_REMOVAL: begin
            if (mean_v < 13'sd0) begin
               result = '0;
            end else if (mean_v > 13'sd255) begin
               result = PIX_W'(SAT_MAX);
            end else begin
               result = mean_v[PIX_W-1:0];
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ===== src/conv3x3_image_filter_unit.sv =====
// Top level of the 3x3 image filter: counters, window, pipeline and CSRs.
// Depends on cv3_pkg, cv3_line_buffer and cv3_kernel.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_in_pixel
//   rsp      out        rsp_valid/rsp_ready   rsp_out_pixel, rsp_out_row, rsp_out_col,
//                                             rsp_frame_end
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// One pixel per clock while rsp_ready stays high; a result passes the window stage and result register.
// Line memories are read one pixel ahead, so their registered read data is ready when the pixel arrives.
// After reset both line memories are cleared, all min(MAX_LINE, 1024) entries
// (1024 by default), with req_ready low; CSR writes are taken meanwhile.
// A stalled rsp fills the window stage, then drops req_ready.
module conv3x3_image_filter_unit #(
   parameter int MAX_LINE = cv3_pkg::MAX_LINE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cv3_pkg::PIX_W-1:0]        req_in_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cv3_pkg::PIX_W-1:0]        rsp_out_pixel,
   output logic [cv3_pkg::ROW_W-1:0]        rsp_out_row,
   output logic [cv3_pkg::COL_W-1:0]        rsp_out_col,
   output logic                             rsp_frame_end,
   input  logic                             csr_wr_en,
   input  logic [cv3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cv3_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cv3_pkg::*;

   localparam int DEPTH     = (MAX_LINE < LINE_CAP) ? MAX_LINE : LINE_CAP;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int WIDTH_LIM = (MAX_LINE - 2 < WIDTH_CAP) ? MAX_LINE - 2 : WIDTH_CAP;

   filter_mode_type mode_ff;
   logic [COL_W-1:0] width_ff;
   logic [ROW_W-1:0] height_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   pixel_type        win_ff [6];

   logic             s1_valid_ff, s1_valid_in;
   window_type       s1_win_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_end_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        rsp_pixel_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic             rsp_end_ff;

   logic [COL_W-1:0]  eff_w, last_col;
   logic [ROW_W-1:0]  eff_h, last_row;
   logic              row_end, frame_last, produce;
   logic              out_free, s1_free, accept, lb_busy;
   logic [ADDR_W-1:0] rd_addr;
   pixel_type         top, mid;
   lb_write_type      lb_wr;
   pixel_type         kernel_out;

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SMOOTH;
         width_ff  <= COL_W'(WIDTH_RESET);
         height_ff <= ROW_W'(HEIGHT_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FILTER_MODE:  mode_ff   <= filter_mode_type'(csr_wdata[1:0]);
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[COL_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = COL_W'(1);
      end else if (width_ff > COL_W'(WIDTH_LIM)) begin
         eff_w = COL_W'(WIDTH_LIM);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (height_ff > ROW_W'(HEIGHT_CAP)) begin
         eff_h = ROW_W'(HEIGHT_CAP);
      end else begin
         eff_h = height_ff;
      end
      last_col = eff_w + COL_W'(1);
      last_row = eff_h + ROW_W'(1);
   end

   assign row_end    = (col_ff >= last_col);
   assign frame_last = row_end && (row_ff >= last_row);
   assign produce    = (row_ff >= ROW_W'(FIRST_OUT)) && (col_ff >= COL_W'(FIRST_OUT));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_ready = !lb_busy && s1_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (row_end) begin
         col_in = '0;
         row_in = (row_ff >= last_row) ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Read one column ahead so the memory data is ready when the pixel arrives.
   assign rd_addr = accept ? col_in[ADDR_W-1:0] : col_ff[ADDR_W-1:0];

   always_comb begin
      lb_wr.en             = accept;
      lb_wr.above_data     = req_in_pixel;
      lb_wr.two_above_data = mid;
   end

   cv3_line_buffer #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_buffer (
      .clock        (clock),
      .reset        (reset),
      .wr           (lb_wr),
      .wr_addr      (col_ff[ADDR_W-1:0]),
      .rd_addr      (rd_addr),
      .rd_above     (mid),
      .rd_two_above (top),
      .busy         (lb_busy)
   );

   // Window columns: slots 0..2 the older column, 3..5 the newer (top, mid, bottom).
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= req_in_pixel;
      end
   end

   // Window stage
   assign s1_valid_in = accept && produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && s1_valid_in) begin
         s1_win_ff <= {req_in_pixel, win_ff[5], win_ff[2],
                       mid, win_ff[4], win_ff[1],
                       top, win_ff[3], win_ff[0]};
         s1_row_ff <= row_ff - ROW_W'(FIRST_OUT);
         s1_col_ff <= col_ff - COL_W'(FIRST_OUT);
         s1_end_ff <= frame_last;
      end
   end

   cv3_kernel u_kernel (
      .win    (s1_win_ff),
      .mode   (mode_ff),
      .result (kernel_out)
   );

   // Result register
   assign rsp_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_pixel_ff <= kernel_out;
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= s1_col_ff;
         rsp_end_ff   <= s1_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_frame_end = rsp_end_ff;

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      lb_busy |-> !req_ready)
      else $error("request accepted during line memory clear");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(DEPTH - 1))
      else $error("column counter beyond line memory depth");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && row_end |=> col_ff == '0)
      else $error("column counter did not wrap at row end");

   a_window_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("window stage lost while result stalled");

   a_result_staged: assert property (@(posedge clock) disable iff (reset)
      accept && produce |=> s1_valid_ff)
      else $error("producing request did not reach window stage");

endmodule
